// File: rtl/page_map_frame_allocator_macros.svh
// Assertion macros for the port-level checker file.
`ifndef PAGE_MAP_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_MAP_FRAME_ALLOCATOR_MACROS_SVH

// ante implies cons in the same cycle
`define PMFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmfa: implication check failed");

// ante implies cons in the next cycle
`define PMFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmfa: next-cycle check failed");

`endif

// File: rtl/pmfa_pkg.sv
`default_nettype none
package pmfa_pkg;

   localparam int NFRAMES = 4096;
   localparam int NPAGES  = 4096;

   // wide enough for any frame or page count in range
   localparam int WIDE_W = 21;

   localparam int BM_WORDS = (NFRAMES + 31) / 32;
   localparam int WORD_AW  = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
   localparam int PAGE_AW  = (NPAGES > 1) ? $clog2(NPAGES) : 1;
   localparam int FRAME_W  = ($clog2(NFRAMES) > 12) ? $clog2(NFRAMES) : 12;
   localparam int PT_W     = FRAME_W + 1;

   localparam int CLR_DEPTH = (NPAGES > BM_WORDS) ? NPAGES : BM_WORDS;
   localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

   localparam logic [2:0] REQ_IDENTITY = 3'd0;
   localparam logic [2:0] REQ_ANY      = 3'd1;
   localparam logic [2:0] REQ_GIVEN    = 3'd2;
   localparam logic [2:0] REQ_UNMAP    = 3'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFREE = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   typedef struct packed {
      logic                 en;
      logic [WORD_AW-1:0]   addr;
      logic [31:0]          data;
   } bm_wr_type;

   // index of the lowest set bit of a one-hot word
   function automatic logic [4:0] onehot_index(input logic [31:0] oh);
      logic [4:0] idx;
      idx = '0;
      for (int j = 0; j < 32; j++) begin
         if (oh[j]) begin
            idx = idx | 5'(j);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// File: rtl/pmfa_bitmap.sv
`default_nettype none
// Frame bitmap store with a first-free-bit finder on the read word.
module pmfa_bitmap (
   input  wire logic                          clock,
   input  wire pmfa_pkg::bm_wr_type           wr,
   input  wire logic [pmfa_pkg::WORD_AW-1:0]  rd_addr,
   output logic [31:0]                        rd_data,
   output logic                               free_any,
   output logic [4:0]                         free_bit
);

   logic [31:0] mem [pmfa_pkg::BM_WORDS];
   logic [31:0] rd_data_ff;
   logic [31:0] inv;
   logic [31:0] lowest;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // isolate lowest zero bit: x & -x on the inverted word
   assign inv      = ~rd_data_ff;
   assign lowest   = inv & (~inv + 32'd1);
   assign free_any = (rd_data_ff != pmfa_pkg::FULL_WORD);
   assign free_bit = pmfa_pkg::onehot_index(lowest);
   assign rd_data  = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/page_map_frame_allocator.sv
`default_nettype none
// Page table with a first-fit frame allocator. A request is taken at a rising
// edge with start high and busy low; busy then stays high until the result,
// which appears on the rsp_ ports for exactly one cycle with rsp_valid high.
// The receiver cannot stall: a result not taken in that cycle is gone. After
// reset the block runs a clearing pass over every page-table entry and every
// bitmap word, with busy high. Per request: an out-of-table page answers from
// S_DECODE; query and out-of-range maps go from S_DECODE to S_PT_OUT; unmap
// answers from S_UN_CHK when the page is absent, else goes on through S_UN_RD
// and S_UN_WR; identity and given-frame maps go through S_MAP_RD and S_MAP_WR.
// A map-any request scans the bitmap one 32-bit word per cycle through the
// single read port, then goes to S_MAP_RD and S_MAP_WR at the first word with
// a free frame, or to S_PT_OUT with no-free status when every frame is used.
// The next request may be started in the cycle the result strobe is shown.
module page_map_frame_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic [11:0] req_page_index,
   input  wire logic [11:0] req_frame_number,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [11:0]      rsp_mapped_frame,
   output logic             rsp_present
);

   localparam int WIDE_W  = pmfa_pkg::WIDE_W;
   localparam int WORD_AW = pmfa_pkg::WORD_AW;
   localparam int FRAME_W = pmfa_pkg::FRAME_W;
   localparam int PT_W    = pmfa_pkg::PT_W;
   localparam int CLR_W   = pmfa_pkg::CLR_W;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_MAP_RD = 4'd4;
   localparam logic [3:0] S_MAP_WR = 4'd5;
   localparam logic [3:0] S_PT_OUT = 4'd6;
   localparam logic [3:0] S_UN_CHK = 4'd7;
   localparam logic [3:0] S_UN_RD  = 4'd8;
   localparam logic [3:0] S_UN_WR  = 4'd9;

   localparam logic [WORD_AW-1:0] WORD_LAST = WORD_AW'(pmfa_pkg::BM_WORDS - 1);
   localparam logic [CLR_W-1:0]   CLR_LAST  = CLR_W'(pmfa_pkg::CLR_DEPTH - 1);

   // sequencer and request registers
   logic [3:0]          state_ff, state_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic [2:0]          type_ff, type_in;
   logic [11:0]         page_ff, page_in;
   logic [11:0]         given_ff, given_in;
   logic [1:0]          status_ff, status_in;
   logic [FRAME_W-1:0]  f_ff, f_in;
   logic [WORD_AW-1:0]  scan_ff, scan_in;
   logic [WORD_AW-1:0]  chk_word_ff, chk_word_in;
   logic                chk_ff, chk_in;

   // result beat
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [11:0]         rsp_frame_ff, rsp_frame_in;
   logic                rsp_present_ff, rsp_present_in;

   // page table: frame number plus present bit on top
   logic [PT_W-1:0]     pt_mem [pmfa_pkg::NPAGES];
   logic [PT_W-1:0]     pt_rdata_ff;
   logic                pt_we;
   logic [PT_W-1:0]     pt_wdata;
   logic [pmfa_pkg::PAGE_AW-1:0] pt_addr;

   // bitmap side
   pmfa_pkg::bm_wr_type bm_wr;
   logic [WORD_AW-1:0]  bm_raddr;
   logic [31:0]         bm_rdata;
   logic                bm_free_any;
   logic [4:0]          bm_free_bit;

   logic [WIDE_W-1:0]   page_w, given_w, f_w, found_w, clr_w;
   logic [WORD_AW-1:0]  f_word;
   logic [31:0]         f_mask;
   logic                accept;
   logic                pt_present;
   logic [FRAME_W-1:0]  pt_frame;

   assign accept     = start && (state_ff == S_IDLE);
   assign page_w     = WIDE_W'(page_ff);
   assign given_w    = WIDE_W'(given_ff);
   assign f_w        = WIDE_W'(f_ff);
   assign clr_w      = WIDE_W'(clr_ff);
   assign f_word     = f_w[5 +: WORD_AW];
   assign f_mask     = 32'd1 << f_w[4:0];
   assign found_w    = WIDE_W'({chk_word_ff, bm_free_bit});
   assign pt_present = pt_rdata_ff[FRAME_W];
   assign pt_frame   = pt_rdata_ff[FRAME_W-1:0];

   // during the clearing pass the table is addressed by the sweep counter
   assign pt_addr  = (state_ff == S_CLEAR) ? clr_w[pmfa_pkg::PAGE_AW-1:0]
                                           : page_w[pmfa_pkg::PAGE_AW-1:0];
   assign bm_raddr = (state_ff == S_SCAN) ? scan_ff : f_word;

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_addr] <= pt_wdata;
      end
      pt_rdata_ff <= pt_mem[pt_addr];
   end

   pmfa_bitmap u_bitmap (
      .clock    (clock),
      .wr       (bm_wr),
      .rd_addr  (bm_raddr),
      .rd_data  (bm_rdata),
      .free_any (bm_free_any),
      .free_bit (bm_free_bit)
   );

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      type_in        = type_ff;
      page_in        = page_ff;
      given_in       = given_ff;
      status_in      = status_ff;
      f_in           = f_ff;
      scan_in        = scan_ff;
      chk_word_in    = chk_word_ff;
      chk_in         = chk_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_present_in = rsp_present_ff;
      pt_we          = 1'b0;
      pt_wdata       = '0;
      bm_wr.en       = 1'b0;
      bm_wr.addr     = f_word;
      bm_wr.data     = '0;

      case (state_ff)
         S_CLEAR: begin
            pt_we      = (clr_w < WIDE_W'(pmfa_pkg::NPAGES));
            bm_wr.en   = (clr_w < WIDE_W'(pmfa_pkg::BM_WORDS));
            bm_wr.addr = clr_w[WORD_AW-1:0];
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               type_in   = req_type;
               page_in   = req_page_index;
               given_in  = req_frame_number;
               status_in = pmfa_pkg::ST_OK;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            scan_in = '0;
            chk_in  = 1'b0;
            if (page_w >= WIDE_W'(pmfa_pkg::NPAGES)) begin
               // page beyond the table: plain ok, nothing present
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pmfa_pkg::ST_OK;
               rsp_frame_in   = '0;
               rsp_present_in = 1'b0;
               state_in       = S_IDLE;
            end else begin
               case (type_ff)
                  pmfa_pkg::REQ_IDENTITY: begin
                     if (page_w >= WIDE_W'(pmfa_pkg::NFRAMES)) begin
                        status_in = pmfa_pkg::ST_RANGE;
                        state_in  = S_PT_OUT;
                     end else begin
                        f_in     = page_w[FRAME_W-1:0];
                        state_in = S_MAP_RD;
                     end
                  end
                  pmfa_pkg::REQ_ANY: begin
                     state_in = S_SCAN;
                  end
                  pmfa_pkg::REQ_GIVEN: begin
                     if (given_w >= WIDE_W'(pmfa_pkg::NFRAMES)) begin
                        status_in = pmfa_pkg::ST_RANGE;
                        state_in  = S_PT_OUT;
                     end else begin
                        f_in     = given_w[FRAME_W-1:0];
                        state_in = S_MAP_RD;
                     end
                  end
                  pmfa_pkg::REQ_UNMAP: begin
                     state_in = S_UN_CHK;
                  end
                  default: begin
                     // query and unknown codes
                     state_in = S_PT_OUT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue word scan_ff while checking the word read last cycle
            scan_in     = (scan_ff == WORD_LAST) ? scan_ff : scan_ff + WORD_AW'(1);
            chk_in      = 1'b1;
            chk_word_in = scan_ff;
            if (chk_ff) begin
               if (bm_free_any && (found_w < WIDE_W'(pmfa_pkg::NFRAMES))) begin
                  f_in     = found_w[FRAME_W-1:0];
                  state_in = S_MAP_RD;
               end else if (bm_free_any || (chk_word_ff == WORD_LAST)) begin
                  status_in = pmfa_pkg::ST_NOFREE;
                  state_in  = S_PT_OUT;
               end
            end
         end
         S_MAP_RD: begin
            state_in = S_MAP_WR;
         end
         S_MAP_WR: begin
            bm_wr.en       = 1'b1;
            bm_wr.data     = bm_rdata | f_mask;
            pt_we          = 1'b1;
            pt_wdata       = {1'b1, f_ff};
            rsp_valid_in   = 1'b1;
            rsp_status_in  = pmfa_pkg::ST_OK;
            rsp_frame_in   = f_ff[11:0];
            rsp_present_in = 1'b1;
            state_in       = S_IDLE;
         end
         S_PT_OUT: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = status_ff;
            rsp_frame_in   = pt_present ? pt_frame[11:0] : 12'd0;
            rsp_present_in = pt_present;
            state_in       = S_IDLE;
         end
         S_UN_CHK: begin
            if (pt_present) begin
               f_in     = pt_frame;
               state_in = S_UN_RD;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pmfa_pkg::ST_OK;
               rsp_frame_in   = '0;
               rsp_present_in = 1'b0;
               state_in       = S_IDLE;
            end
         end
         S_UN_RD: begin
            state_in = S_UN_WR;
         end
         S_UN_WR: begin
            // free the frame the entry held, then drop the entry
            bm_wr.en       = 1'b1;
            bm_wr.data     = bm_rdata & ~f_mask;
            pt_we          = 1'b1;
            pt_wdata       = '0;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = pmfa_pkg::ST_OK;
            rsp_frame_in   = '0;
            rsp_present_in = 1'b0;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      page_ff        <= page_in;
      given_ff       <= given_in;
      status_ff      <= status_in;
      f_ff           <= f_in;
      scan_ff        <= scan_in;
      chk_word_ff    <= chk_word_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_present_ff <= rsp_present_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_mapped_frame = rsp_frame_ff;
   assign rsp_present      = rsp_present_ff;

endmodule
`default_nettype wire

// File: rtl/pmfa_checker.sv
`default_nettype none
`include "page_map_frame_allocator_macros.svh"
// Port-level checks on the allocator.
module pmfa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [11:0] rsp_mapped_frame,
   input wire logic        rsp_present
);

   // a taken request drives the block busy
   `PMFA_ASSERT_NEXT(a_busy_after_beat, clock, reset, start && !busy, busy)
   // results are single beats, never back to back
   `PMFA_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid)
   // absent entries report frame zero
   `PMFA_ASSERT_IMPL(a_absent_frame, clock, reset, rsp_valid && !rsp_present,
                     rsp_mapped_frame == 12'd0)
   // status code three is never produced
   `PMFA_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid,
                     rsp_status == pmfa_pkg::ST_OK || rsp_status == pmfa_pkg::ST_NOFREE ||
                     rsp_status == pmfa_pkg::ST_RANGE)

endmodule

bind page_map_frame_allocator pmfa_checker u_pmfa_checker (.*);
`default_nettype wire

// File: bench/page_map_frame_allocator_tb.sv
`default_nettype none
module page_map_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFRAMES = pmfa_pkg::NFRAMES;
   localparam int NPAGES  = pmfa_pkg::NPAGES;

   localparam logic [2:0] REQ_IDENTITY = pmfa_pkg::REQ_IDENTITY;
   localparam logic [2:0] REQ_ANY      = pmfa_pkg::REQ_ANY;
   localparam logic [2:0] REQ_GIVEN    = pmfa_pkg::REQ_GIVEN;
   localparam logic [2:0] REQ_UNMAP    = pmfa_pkg::REQ_UNMAP;

   localparam logic [1:0] ST_OK     = pmfa_pkg::ST_OK;
   localparam logic [1:0] ST_NOFREE = pmfa_pkg::ST_NOFREE;
   localparam logic [1:0] ST_RANGE  = pmfa_pkg::ST_RANGE;

   // Request codes the package leaves out: query, and the reserved span
   // that the block treats as a query.
   localparam logic [2:0] REQ_QUERY    = 3'd4;
   localparam logic [2:0] REQ_RSVD_LO  = 3'd5;
   localparam logic [2:0] REQ_RSVD_MID = 3'd6;
   localparam logic [2:0] REQ_RSVD_HI  = 3'd7;

   // identity maps that fill the low bitmap words
   localparam int FILL_PAGES   = 1024;
   localparam int RANDOM_BEATS = 900;
   // Slowest legal run: about 1950 requests, each a full scan plus the longest
   // sender gap, plus the clearing pass; taken 4x.
   localparam int CYCLE_LIMIT  = 1_500_000;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] frame;
      logic        present;
   } alloc_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [11:0] req_page_index;
   logic [11:0] req_frame_number;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_mapped_frame;
   logic        rsp_present;

   // Shadow state of the allocator: one flag per frame, one entry per page.
   bit          frame_used   [NFRAMES];
   logic [11:0] page_frame   [NPAGES];
   bit          page_present [NPAGES];

   alloc_result_type pending_results[$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count    = 0;

   page_map_frame_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_page_index   (req_page_index),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_mapped_frame (rsp_mapped_frame),
      .rsp_present      (rsp_present)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Point a page at a frame and mark the frame used. Sharing is legal.
   function automatic void claim_frame(input logic [11:0] page, input logic [11:0] frame);
      page_frame[page]   = frame;
      page_present[page] = 1'b1;
      frame_used[frame]  = 1'b1;
   endfunction

   // Apply one request to the shadow state and return the answer the block
   // must give for it.
   function automatic alloc_result_type predict_mapping(input logic [2:0]  kind,
                                                        input logic [11:0] page,
                                                        input logic [11:0] given);
      alloc_result_type res;
      int               free_idx;
      res      = '0;
      free_idx = -1;
      // pages past the table are ignored outright
      if (int'(page) >= NPAGES) begin
         return res;
      end
      res.status = ST_OK;
      case (kind)
         REQ_IDENTITY: begin
            if (int'(page) >= NFRAMES) res.status = ST_RANGE;
            else claim_frame(page, page);
         end
         REQ_ANY: begin
            // first fit: lowest clear bit wins
            for (int f = 0; f < NFRAMES; f++) begin
               if (!frame_used[f] && free_idx < 0) free_idx = f;
            end
            if (free_idx < 0) res.status = ST_NOFREE;
            else claim_frame(page, 12'(free_idx));
         end
         REQ_GIVEN: begin
            if (int'(given) >= NFRAMES) res.status = ST_RANGE;
            else claim_frame(page, given);
         end
         REQ_UNMAP: begin
            // frees the frame the entry held, even if another page shares it
            if (page_present[page]) begin
               frame_used[page_frame[page]] = 1'b0;
               page_frame[page]             = '0;
               page_present[page]           = 1'b0;
            end
         end
         default: ;  // query and reserved codes leave state alone
      endcase
      res.present = page_present[page];
      res.frame   = page_present[page] ? page_frame[page] : 12'd0;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every strobe is matched against the oldest prediction.
   // Sampled at the edge, so values are the ones shown during the cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_mapped_frame !== want.frame) begin
               $error("mapped_frame: expected %0d, got %0d", want.frame, rsp_mapped_frame);
               mismatch_count++;
            end
            if (rsp_present !== want.present) begin
               $error("present: expected %0d, got %0d", want.present, rsp_present);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Present one request and hold it until the block takes it. Start is left
   // high so a back-to-back beat never drops it for a step.
   task automatic send_req(input logic [2:0] kind, input logic [11:0] page,
                           input logic [11:0] given);
      start            <= 1'b1;
      req_type         <= kind;
      req_page_index   <= page;
      req_frame_number <= given;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(predict_mapping(kind, page, given));
   endtask

   // Random sender gap: mostly none or short, now and then long.
   task automatic idle_gap();
      int unsigned pick;
      int unsigned cycles;
      pick   = $urandom_range(0, 99);
      cycles = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked beats: field extremes, every request code, sharing,
   // remapping, unmap of absent pages and the reserved codes.
   task automatic test_directed();
      send_req(REQ_QUERY,    12'd0,    12'hFFF); idle_gap();  // empty entry
      send_req(REQ_UNMAP,    12'd3,    12'd0);   idle_gap();  // unmap absent
      send_req(REQ_IDENTITY, 12'd0,    12'hFFF); idle_gap();
      send_req(REQ_IDENTITY, 12'hFFF,  12'd0);   idle_gap();
      send_req(REQ_ANY,      12'd5,    12'hA5A); idle_gap();  // lowest free -> 1
      send_req(REQ_GIVEN,    12'd7,    12'hFFF); idle_gap();  // shares top frame
      send_req(REQ_GIVEN,    12'd8,    12'd0);   idle_gap();  // shares frame 0
      send_req(REQ_GIVEN,    12'd5,    12'd100); idle_gap();  // remap, old stays used
      send_req(REQ_ANY,      12'd9,    12'd0);   idle_gap();
      send_req(REQ_UNMAP,    12'd7,    12'd0);   idle_gap();  // frees shared frame
      send_req(REQ_QUERY,    12'hFFF,  12'd0);   idle_gap();  // still present
      send_req(REQ_ANY,      12'd10,   12'h555); idle_gap();  // next lowest free -> 3
      send_req(REQ_RSVD_LO,  12'd5,    12'hFFF); idle_gap();
      send_req(REQ_RSVD_MID, 12'd9,    12'd0);   idle_gap();
      send_req(REQ_RSVD_HI,  12'hFFF,  12'hFFF); idle_gap();
      send_req(REQ_UNMAP,    12'd0,    12'hFFF); idle_gap();
      send_req(REQ_UNMAP,    12'd8,    12'd0);   idle_gap();  // frame 0 already free
      send_req(REQ_GIVEN,    12'hAAA,  12'h555); idle_gap();
      send_req(REQ_GIVEN,    12'h555,  12'hAAA); idle_gap();
      send_req(REQ_QUERY,    12'hAAA,  12'd0);   idle_gap();
      send_req(REQ_UNMAP,    12'hFFF,  12'd0);   idle_gap();
      drain_results();
   endtask

   // Fill the low bitmap words by identity maps so first fit has to scan
   // past full words, then free one frame and check first fit finds it.
   task automatic test_fill_frames();
      int unsigned victim;
      for (int p = 0; p < FILL_PAGES; p++) begin
         send_req(REQ_IDENTITY, 12'(p), 12'($urandom_range(0, 4095)));
         if (p % 64 == 0) idle_gap();
      end
      send_req(REQ_ANY, 12'd17, 12'd0);    idle_gap();
      send_req(REQ_ANY, 12'hFFF, 12'hFFF); idle_gap();
      victim = $urandom_range(0, FILL_PAGES - 1);
      send_req(REQ_UNMAP, 12'(victim), 12'd0);                          idle_gap();
      send_req(REQ_ANY, 12'($urandom_range(0, 4095)), 12'd0);           idle_gap();
      send_req(REQ_ANY, 12'd18, 12'd0);                                 idle_gap();
      drain_results();
   endtask

   // Mixed traffic on top of the filled low words: unmaps scatter holes,
   // map-any closes the lowest one, so scans stop at many depths. Half the
   // pages come from a small pool so remaps and re-unmaps are common.
   task automatic test_random_traffic();
      int unsigned pick;
      logic [2:0]  kind;
      logic [11:0] page;
      logic [11:0] given;
      bit          burst;
      burst = 1'b0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
         if (n % 400 == 399) drain_results();
         pick = $urandom_range(0, 99);
         if      (pick < 10) kind = REQ_IDENTITY;
         else if (pick < 35) kind = REQ_ANY;
         else if (pick < 50) kind = REQ_GIVEN;
         else if (pick < 85) kind = REQ_UNMAP;
         else if (pick < 95) kind = REQ_QUERY;
         else                kind = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
         page = $urandom_range(0, 1) ? 12'($urandom_range(0, 255))
                                     : 12'($urandom_range(0, 4095));
         pick = $urandom_range(0, 99);
         if      (pick < 8)  given = 12'd0;
         else if (pick < 16) given = 12'hFFF;
         else                given = 12'($urandom_range(0, 4095));
         send_req(kind, page, given);
         if (!burst) idle_gap();
      end
      start <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_type         <= '0;
      req_page_index   <= '0;
      req_frame_number <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // busy covers the clearing pass, so the first beat simply waits on it

      test_directed();
      test_fill_frames();
      test_random_traffic();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
